>>> rtl/ialu_pkg.sv
// ialu_pkg: opcodes, widths and pipeline types for the integer alu
// no dependencies
package ialu_pkg;

	localparam int unsigned WordW = 32;
	localparam int unsigned OpW = 4;
	localparam int unsigned DivStages = 4;
	localparam int unsigned BitsPerStage = WordW / DivStages;

	typedef logic [WordW-1:0] word_t;
	typedef logic [OpW-1:0] op_t;

	localparam op_t OP_ADD = 4'd0;
	localparam op_t OP_SUB = 4'd1;
	localparam op_t OP_AND = 4'd2;
	localparam op_t OP_XOR = 4'd3;
	localparam op_t OP_OR  = 4'd4;
	localparam op_t OP_ROT = 4'd5;
	localparam op_t OP_MUL = 4'd6;
	localparam op_t OP_DIV = 4'd7;
	localparam op_t OP_MOD = 4'd8;
	localparam op_t OP_CMP = 4'd9;

	localparam word_t SIGN_BIT = 32'h8000_0000;

	typedef struct packed {
		logic  is_div;
		logic  is_mod;
		logic  neg;
		logic  dz;
		word_t simple;
	} div_ctl_t;

endpackage

>>> rtl/ialu_divider.sv
// ialu_divider: pipelined restoring divider of unsigned magnitudes
// uses ialu_pkg; a fixed number of quotient bits per stage, advance-enabled
module ialu_divider import ialu_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     adv,
	input  logic     in_valid,
	input  word_t    dividend,
	input  word_t    divisor,
	input  div_ctl_t in_ctl,
	output logic     out_valid,
	output word_t    quot,
	output word_t    rem,
	output div_ctl_t out_ctl
);

	logic     v_q   [DivStages];
	word_t    q_q   [DivStages];
	word_t    r_q   [DivStages];
	word_t    d_q   [DivStages];
	div_ctl_t c_q   [DivStages];

	function automatic logic [2*WordW-1:0] div_step(word_t qin, word_t rin, word_t d);
		logic [WordW:0] r;
		word_t q;
		q = qin;
		r = {1'b0, rin};
		for (int i = 0; i < BitsPerStage; i++) begin
			r = {r[WordW-1:0], q[WordW-1]};
			q = {q[WordW-2:0], 1'b0};
			if (r >= {1'b0, d}) begin
				r = r - {1'b0, d};
				q[0] = 1'b1;
			end
		end
		return {q, r[WordW-1:0]};
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < DivStages; s++) v_q[s] <= 1'b0;
		end else if (adv) begin
			v_q[0] <= in_valid;
			for (int s = 1; s < DivStages; s++) v_q[s] <= v_q[s-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			{q_q[0], r_q[0]} <= div_step(dividend, '0, divisor);
			d_q[0] <= divisor;
			c_q[0] <= in_ctl;
			for (int s = 1; s < DivStages; s++) begin
				{q_q[s], r_q[s]} <= div_step(q_q[s-1], r_q[s-1], d_q[s-1]);
				d_q[s] <= d_q[s-1];
				c_q[s] <= c_q[s-1];
			end
		end
	end

	assign out_valid = v_q[DivStages-1];
	assign quot = q_q[DivStages-1];
	assign rem = r_q[DivStages-1];
	assign out_ctl = c_q[DivStages-1];

endmodule

>>> rtl/integer_alu_with_signed_div_mod_unit.sv
// integer alu with signed divide and modulus, six-stage pipeline
// input passes stage 1, the divider and stage 6 to the result; one item per cycle when not stalled
// stage 1 decodes and takes magnitudes and multiplies, stages 2-5 divide
// (8 quotient bits each), stage 6 fixes signs; whole pipe stalls on output back-pressure
// asynchronous active-low reset clears all valid bits; no other state
// uses ialu_pkg and ialu_divider
module integer_alu_with_signed_div_mod_unit import ialu_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  op_t   opcode,
	input  word_t operand_a,
	input  word_t operand_b,
	output logic  out_valid,
	input  logic  out_ready,
	output word_t result_value,
	output logic  divide_by_zero
);

	logic     adv;
	logic     v_s1;
	word_t    ma_s1, mb_s1, mul_s1;
	div_ctl_t c_s1;
	logic     is_mul_s1;
	div_ctl_t dic;
	logic     dv_v;
	word_t    dq, dr;
	div_ctl_t dc;
	logic     v_s6;
	word_t    res_s6;
	logic     dz_s6;

	word_t    ma, mb, rot, simple;
	logic [4:0] rn;
	div_ctl_t c;
	word_t    fin;

	assign adv = !v_s6 || out_ready;
	assign in_ready = adv;

	always_comb begin
		ma = operand_a[WordW-1] ? word_t'(0 - operand_a) : operand_a;
		mb = operand_b[WordW-1] ? word_t'(0 - operand_b) : operand_b;
		if (operand_b[WordW-1]) begin
			rn = 5'(0 - operand_b[4:0]);
			rot = (operand_a << rn) | (operand_a >> (6'd32 - {1'b0, rn}));
		end else begin
			rn = operand_b[4:0];
			rot = (operand_a >> rn) | (operand_a << (6'd32 - {1'b0, rn}));
		end
		if (rn == 5'd0) rot = operand_a;
		simple = '0;
		case (opcode)
			OP_ADD: simple = operand_a + operand_b;
			OP_SUB: simple = operand_a - operand_b;
			OP_AND: simple = operand_a & operand_b;
			OP_XOR: simple = operand_a ^ operand_b;
			OP_OR:  simple = operand_a | operand_b;
			OP_ROT: simple = rot;
			OP_CMP: begin
				simple[0] = $signed(operand_a) < $signed(operand_b);
				simple[1] = $signed(operand_a) > $signed(operand_b);
				simple[2] = operand_a == operand_b;
				simple[3] = operand_a != operand_b;
			end
			default: simple = '0;
		endcase
		c.is_div = opcode == OP_DIV;
		c.is_mod = opcode == OP_MOD;
		c.neg = operand_a[WordW-1] ^ operand_b[WordW-1];
		c.dz = (c.is_div || c.is_mod) && operand_b == '0;
		c.simple = simple;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ma_s1 <= ma;
			mb_s1 <= mb;
			mul_s1 <= operand_a * operand_b;
			is_mul_s1 <= opcode == OP_MUL;
			c_s1 <= c;
		end
	end

	always_comb begin
		dic = c_s1;
		if (is_mul_s1) begin
			dic = '0;
			dic.simple = mul_s1;
		end
	end

	ialu_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (v_s1),
		.dividend  (ma_s1),
		.divisor   (mb_s1),
		.in_ctl    (dic),
		.out_valid (dv_v),
		.quot      (dq),
		.rem       (dr),
		.out_ctl   (dc)
	);

	always_comb begin
		fin = dc.simple;
		if (dc.dz) fin = '0;
		else if (dc.is_div) fin = dc.neg ? word_t'(0 - dq) : dq;
		else if (dc.is_mod) fin = dc.neg ? word_t'(0 - dr) : dr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else if (adv) v_s6 <= dv_v;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s6 <= fin;
			dz_s6 <= dc.dz;
		end
	end

	assign out_valid = v_s6;
	assign result_value = res_s6;
	assign divide_by_zero = dz_s6;

endmodule

>>> rtl/ialu_checker.sv
// ialu_checker: port-level checks on the integer alu
// uses ialu_pkg; bound to integer_alu_with_signed_div_mod_unit
module ialu_checker import ialu_pkg::*; (
	input logic  clk,
	input logic  arst_n,
	input logic  in_valid,
	input logic  in_ready,
	input logic  out_valid,
	input logic  out_ready,
	input word_t result_value,
	input logic  divide_by_zero
);

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_value))
		else $error("stalled result changed");

	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while pipe stalled");

	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && divide_by_zero |-> result_value == '0)
		else $error("divide by zero with nonzero result");

	a_free_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("ready low with empty output");

endmodule

bind integer_alu_with_signed_div_mod_unit ialu_checker u_chk (.*);
